// File: sv/base64_stream_codec_core_macros.svh
// Assertion helpers shared by the codec modules.
// Each helper expects signals named clk and arst_n in the scope where it is used.
`ifndef BASE64_STREAM_CODEC_CORE_MACROS_SVH
`define BASE64_STREAM_CODEC_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define B64_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("base64 codec check failed");
// Next-cycle implication, checked out of reset.
`define B64_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("base64 codec check failed");
`else
`define B64_ASSERT_IMPL(label, ante, cons)
`define B64_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: sv/b64sc_pkg.sv
package b64sc_pkg;

	// Default number of jobs held between the front and the back.
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// Characters with a special meaning.
	localparam logic [7:0] CHAR_PAD   = 8'h3D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	// Mode codes of the direction register.
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// One job: the one to four results that a single input item causes.
	typedef struct packed {
		logic [3:0][7:0] data;     // result bytes, entry 0 goes out first
		logic [1:0]      last_idx; // index of the final result of the job
		logic            valid;    // out_valid for every result of the job
		logic            error;    // out_error for every result of the job
		logic            last;     // out_last on the final result of the job
	} job_t;

	// Maps a 6-bit value to its character of the standard alphabet.
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			r = 8'h61 + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			r = 8'h30 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			r = CHAR_PLUS;
		end else begin
			r = CHAR_SLASH;
		end
		return r;
	endfunction

	// Maps a character to {invalid, value}; invalid is set for non-alphabet characters.
	function automatic logic [6:0] dec_sextet(input logic [7:0] c);
		logic [6:0] r;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = {1'b0, 6'(c - 8'h41)};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = {1'b0, 6'(c - 8'h61 + 8'd26)};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 6'(c - 8'h30 + 8'd52)};
		end else if (c == CHAR_PLUS) begin
			r = {1'b0, 6'd62};
		end else if (c == CHAR_SLASH) begin
			r = {1'b0, 6'd63};
		end else begin
			r = {1'b1, 6'd0};
		end
		return r;
	endfunction

	// True for characters that decoding skips.
	function automatic logic is_skip(input logic [7:0] c);
		return (c == CHAR_PAD) || (c == CHAR_LF) || (c == CHAR_CR) ||
			(c == CHAR_SPACE) || (c == CHAR_TAB);
	endfunction

endpackage

// File: sv/b64sc_front.sv
`include "base64_stream_codec_core_macros.svh"

module b64sc_front
	import b64sc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       q_full,
	output logic       push,
	output job_t       push_job
);

	logic        dir_q;
	logic [15:0] acc_q;
	logic [3:0]  fill_q;
	logic        err_q;

	logic        dir_d;
	logic [15:0] acc_d;
	logic [3:0]  fill_d;
	logic        err_d;

	logic        accept;
	logic [23:0] grp;
	logic [6:0]  sext;
	logic [12:0] acc13;
	logic [3:0]  bits;
	logic [2:0]  shamt;

	// A request is taken whenever the queue has room for its job.
	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	// Decode helpers: new accumulator and bit count after one more sextet.
	assign sext  = dec_sextet(in_byte);
	assign acc13 = {acc_q[6:0], sext[5:0]};
	assign bits  = {1'b0, fill_q[2:0]} + 4'd6;
	assign shamt = 3'(bits - 4'd8);

	// Group of three bytes for the encoder, zero-filled for a short tail.
	always_comb begin
		if (fill_q >= 4'd2) begin
			grp = {acc_q, in_byte};
		end else if (fill_q == 4'd1) begin
			grp = {acc_q[7:0], in_byte, 8'h00};
		end else begin
			grp = {in_byte, 16'h0000};
		end
	end

	// State update and job building for one request.
	always_comb begin
		dir_d    = dir_q;
		acc_d    = acc_q;
		fill_d   = fill_q;
		err_d    = err_q;
		push     = 1'b0;
		push_job = '0;
		if (cfg_wen) begin
			dir_d  = cfg_wdata;
			acc_d  = '0;
			fill_d = '0;
			err_d  = 1'b0;
		end else if (accept) begin
			if (dir_q == DIR_ENCODE) begin
				if (fill_q < 4'd2 && !in_last) begin
					acc_d  = {acc_q[7:0], in_byte};
					fill_d = fill_q + 4'd1;
				end else begin
					push             = 1'b1;
					push_job.valid   = 1'b1;
					push_job.last    = in_last;
					push_job.last_idx = 2'd3;
					push_job.data[0] = enc_char(grp[23:18]);
					push_job.data[1] = enc_char(grp[17:12]);
					push_job.data[2] = enc_char(grp[11:6]);
					push_job.data[3] = enc_char(grp[5:0]);
					if (fill_q < 4'd2) begin
						push_job.last = 1'b1;
						push_job.data[3] = CHAR_PAD;
						if (fill_q == 4'd0) begin
							push_job.data[2] = CHAR_PAD;
						end
					end
					acc_d  = '0;
					fill_d = '0;
				end
			end else begin
				if (err_q) begin
					// Requests after an error are dropped up to the end of the message.
					if (in_last) begin
						acc_d  = '0;
						fill_d = '0;
						err_d  = 1'b0;
					end
				end else if (is_skip(in_byte)) begin
					if (in_last) begin
						acc_d         = '0;
						fill_d        = '0;
						push          = 1'b1;
						push_job.last = 1'b1;
					end
				end else if (sext[6]) begin
					acc_d          = '0;
					fill_d         = '0;
					err_d          = !in_last;
					push           = 1'b1;
					push_job.error = 1'b1;
					push_job.last  = 1'b1;
				end else begin
					acc_d  = {3'b000, acc13};
					fill_d = bits;
					if (bits >= 4'd8) begin
						fill_d           = {1'b0, shamt};
						push             = 1'b1;
						push_job.valid   = 1'b1;
						push_job.last    = in_last;
						push_job.data[0] = 8'(acc13 >> shamt);
					end else if (in_last) begin
						push          = 1'b1;
						push_job.last = 1'b1;
					end
					if (in_last) begin
						acc_d  = '0;
						fill_d = '0;
					end
				end
			end
		end
	end

	// Mode and codec state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= DIR_ENCODE;
			acc_q  <= '0;
			fill_q <= '0;
			err_q  <= 1'b0;
		end else begin
			dir_q  <= dir_d;
			acc_q  <= acc_d;
			fill_q <= fill_d;
			err_q  <= err_d;
		end
	end

	`B64_ASSERT_IMPL(a_enc_fill, dir_q == DIR_ENCODE, fill_q <= 4'd2 && !err_q)
	`B64_ASSERT_IMPL(a_dec_fill, dir_q == DIR_DECODE, fill_q <= 4'd6)
	`B64_ASSERT_NEXT(a_cfg_clear, cfg_wen, fill_q == 4'd0 && !err_q && acc_q == 16'h0000)

endmodule

// File: sv/b64sc_queue.sv
`include "base64_stream_codec_core_macros.svh"

module b64sc_queue
	import b64sc_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic empty,
	output job_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Job storage, written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`B64_ASSERT_IMPL(a_no_overrun, push, !full)
	`B64_ASSERT_IMPL(a_no_underrun, pop, !empty)

endmodule

// File: sv/b64sc_back.sv
`include "base64_stream_codec_core_macros.svh"

module b64sc_back
	import b64sc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic [1:0] m_tuser,
	output logic       m_tlast
);

	logic [1:0] idx_q;
	logic       at_end;

	// Results of the head job go out one per cycle while m_tready is high.
	assign at_end   = (idx_q == head.last_idx);
	assign m_tvalid = head_valid;
	assign m_tdata  = head.data[idx_q];
	assign m_tuser  = {head.error, head.valid};
	assign m_tlast  = head.last && at_end;
	assign pop      = m_tvalid && m_tready && at_end;

	// Result index within the head job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (m_tvalid && m_tready) begin
			idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end
	end

	`B64_ASSERT_IMPL(a_idx_range, m_tvalid, idx_q <= head.last_idx)

endmodule

// File: sv/base64_stream_codec_core.sv
// Streaming Base64 codec, standard alphabet. cfg_wdata=0 encodes bytes to text, 1 decodes
// text to bytes; a write also clears any partial message. The front accepts one request
// per cycle as long as the job queue (QUEUE_DEPTH entries) has room, and turns it into a
// job of zero to four results. The back sends one result per cycle from the head job while
// m_tready is high, so an encoded group of three bytes gives four output results and, when
// encoding, the output port sets the sustained rate. Items that give no result never
// occupy the queue.
module base64_stream_codec_core
	import b64sc_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic       cfg_wdata,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_data
	output logic [1:0] m_tuser,   // [0] out_valid, [1] out_error
	output logic       m_tlast
);

	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	job_t push_job;
	job_t head;

	// Request intake, classification and codec state.
	b64sc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// Jobs waiting for the output.
	b64sc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.full    (q_full),
		.empty   (q_empty),
		.head    (head)
	);

	// Result serializer.
	b64sc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(!q_empty),
		.head      (head),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
